/* hdl/assert_macros.svh */
// Assertion helpers shared by the allocator modules.
// Both expect signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same, written as a condition and what it implies in the same cycle.
`define FBA_ASSERT_IMPLY(label, cond, prop, msg) \
   `FBA_ASSERT(label, (cond) |-> (prop), msg)

`endif

/* hdl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, payload types and helpers of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

   localparam int MAX_FRAMES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int PAGE_SHIFT = 12;

   localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BIT_AW     = $clog2(WORD_BITS);

   localparam int COUNT_W = 13;
   localparam int INDEX_W = 12;
   localparam int ADDR_W  = 24;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_MARK  = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_REPLY
   } state_type;

   typedef struct packed {
      mode_type            mode;
      logic [INDEX_W-1:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [INDEX_W-1:0]  granted_frame;
      logic [ADDR_W-1:0]   frame_address;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic [WORD_AW-1:0]   rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic                 found;
      logic                 last;
      logic [BIT_AW-1:0]    bit_idx;
      logic [WORD_BITS-1:0] bit_mask;
   } scan_type;

   function automatic logic [WORD_AW-1:0] word_of(input logic [INDEX_W-1:0] f);
      return WORD_AW'(f >> BIT_AW);
   endfunction

   function automatic logic [ADDR_W-1:0] frame_addr(input logic [INDEX_W-1:0] f);
      logic [ADDR_W+INDEX_W-1:0] wide;
      wide = (ADDR_W+INDEX_W)'(f) << PAGE_SHIFT;
      return wide[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/fba_scan_unit.sv */
// ----------------------------------------------------------------------------
// fba_scan_unit
// Finds the lowest free frame of one bitmap word below the frame limit.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_scan_unit
   import fba_pkg::*;
(
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [WORD_AW-1:0]   word_addr,
   input  wire logic [COUNT_W-1:0]   limit,
   output scan_type                  scan
);

   logic [COUNT_W-1:0]   base;
   logic [COUNT_W-1:0]   rem;
   logic                 in_limit;
   logic [WORD_BITS-1:0] elig_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] lowest;
   logic [BIT_AW-1:0]    bit_idx;

   assign base     = COUNT_W'({word_addr, {BIT_AW{1'b0}}});
   assign in_limit = limit > base;
   assign rem      = limit - base;

   always_comb begin
      if (!in_limit) begin
         elig_mask = '0;
      end else if (rem >= COUNT_W'(WORD_BITS)) begin
         elig_mask = '1;
      end else begin
         elig_mask = (WORD_BITS'(1) << rem[BIT_AW-1:0]) - WORD_BITS'(1);
      end
   end

   // isolate the lowest free bit, then encode it
   assign free_bits = ~word & elig_mask;
   assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (lowest[b]) begin
            bit_idx = bit_idx | BIT_AW'(b);
         end
      end
   end

   assign scan.found    = |free_bits;
   assign scan.last     = !in_limit || (rem <= COUNT_W'(WORD_BITS)) ||
                          (word_addr == WORD_AW'(WORD_COUNT - 1));
   assign scan.bit_idx  = bit_idx;
   assign scan.bit_mask = lowest;

endmodule

`default_nettype wire

/* hdl/fba_ctrl.sv */
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: scans the bitmap one word per cycle for allocate and
// does a read-modify-write of one word for mark and free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fba_ctrl
   import fba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   input  wire logic [COUNT_W-1:0]   limit,
   input  wire logic                 out_free,
   input  wire logic [WORD_BITS-1:0] ram_q,
   output ram_req_type               ram_req,
   output logic                      result_valid,
   output rsp_type                   result
);

   state_type               state_ff, state_in;
   logic [WORD_COUNT-1:0]   valid_ff, valid_in;
   logic [WORD_AW-1:0]      w_ff, w_in;
   mode_type                mode_ff, mode_in;
   logic [INDEX_W-1:0]      idx_ff, idx_in;
   rsp_type                 result_ff, result_in;

   logic [WORD_BITS-1:0]    cur_word;
   logic [WORD_BITS-1:0]    idx_bit;
   logic                    idx_in_range;
   logic [INDEX_W-1:0]      found_frame;
   logic [WORD_AW-1:0]      req_word;
   scan_type                scan;

   // never-written words read as free
   assign cur_word     = valid_ff[w_ff] ? ram_q : '0;
   assign idx_bit      = WORD_BITS'(1) << idx_ff[BIT_AW-1:0];
   assign idx_in_range = COUNT_W'(idx_ff) < limit;
   assign found_frame  = INDEX_W'({w_ff, scan.bit_idx});
   assign req_word     = (req_data.mode == MODE_ALLOC) ? '0 : word_of(req_data.frame_index);

   fba_scan_unit u_scan (
      .word      (cur_word),
      .word_addr (w_ff),
      .limit     (limit),
      .scan      (scan)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  MODE_ALLOC: state_in = ST_SCAN;
                  MODE_MARK:  state_in = ST_MODIFY;
                  MODE_FREE:  state_in = ST_MODIFY;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan.found || scan.last) begin
               state_in = ST_REPLY;
            end
         end
         ST_MODIFY: state_in = ST_REPLY;
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      result_valid    = 1'b0;
      w_in            = w_ff;
      mode_in         = mode_ff;
      idx_in          = idx_ff;
      result_in       = result_ff;
      valid_in        = valid_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = w_ff;
      ram_req.wr_data = cur_word;
      ram_req.rd_addr = w_ff + WORD_AW'(1);
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            ram_req.rd_addr = req_word;
            if (req_valid) begin
               mode_in   = req_data.mode;
               idx_in    = req_data.frame_index;
               w_in      = req_word;
               result_in = '{ok: 1'b0, granted_frame: req_data.frame_index,
                             frame_address: '0};
            end
         end
         ST_SCAN: begin
            if (scan.found) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_data = cur_word | scan.bit_mask;
               valid_in[w_ff]  = 1'b1;
               result_in       = '{ok: 1'b1, granted_frame: found_frame,
                                   frame_address: frame_addr(found_frame)};
            end else if (scan.last) begin
               result_in = '{ok: 1'b0, granted_frame: '0, frame_address: '0};
            end else begin
               w_in = w_ff + WORD_AW'(1);
            end
         end
         ST_MODIFY: begin
            if (idx_in_range) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_data = (mode_ff == MODE_MARK) ? (cur_word | idx_bit)
                                                        : (cur_word & ~idx_bit);
               valid_in[w_ff]  = 1'b1;
               result_in       = '{ok: 1'b1, granted_frame: idx_ff,
                                   frame_address: frame_addr(idx_ff)};
            end else begin
               result_in = '{ok: 1'b0, granted_frame: idx_ff, frame_address: '0};
            end
         end
         ST_REPLY: result_valid = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

   `FBA_ASSERT_IMPLY(a_write_state, ram_req.wr_en, (state_ff == ST_SCAN) || (state_ff == ST_MODIFY), "bitmap write outside scan or modify")
   `FBA_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> (state_ff != ST_IDLE), "accepted transaction did not start")
   `FBA_ASSERT_IMPLY(a_scan_in_limit, state_ff == ST_SCAN, (w_ff == '0) || (COUNT_W'({w_ff, {BIT_AW{1'b0}}}) < limit), "scan went past frame limit")

endmodule

`default_nettype wire

/* hdl/frame_bitmap_allocator_unit.sv */
// Frame bitmap allocator: one used/free bit per page frame in a 128 x 32 RAM.
// Mode 3 goes straight to the reply state, mark/free pass through the
// read-modify-write state, and allocate scans from word 0 up to the word
// holding the grant or the last word in the limit, one RAM word per cycle.
// One transaction at a time: a new request is accepted only in idle.
// Reset (synchronous) clears the per-word valid bits and sets frame_count 4096.
`default_nettype none

`include "assert_macros.svh"

module frame_bitmap_allocator_unit
   import fba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   logic [COUNT_W-1:0]   frame_count_ff;
   logic [COUNT_W-1:0]   limit;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 out_free;
   logic                 result_valid;
   rsp_type              result;
   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         frame_count_ff <= csr_wr_data;
      end
   end

   assign limit = (frame_count_ff > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                           : frame_count_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   fba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_q)
   );

   fba_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .limit        (limit),
      .out_free     (out_free),
      .ram_q        (ram_q),
      .ram_req      (ram_req),
      .result_valid (result_valid),
      .result       (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FBA_ASSERT_IMPLY(a_fail_no_addr, rsp_valid_ff && !rsp_data_ff.ok, rsp_data_ff.frame_address == '0, "failed transaction carries an address")

endmodule

`default_nettype wire

/* test/frame_bitmap_allocator_checker.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_checker
// Watches the request, response and CSR ports of the frame bitmap allocator.
// It keeps its own frame bitmap and frame count, predicts the response of
// every accepted request and compares accepted responses in order.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_checker
   import fba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire req_type            req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire rsp_type            rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   output int                      fail_count,
   output int                      outstanding,
   output int                      checked,
   output int                      grants,
   output int                      rejects
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [WORD_BITS-1:0] used_map [WORD_COUNT];
   logic [COUNT_W-1:0]   frame_limit;
   rsp_type              expected_rsps [$];
   int                   errors;

   // Applies one request to the local bitmap and returns its response.
   function automatic rsp_type serve_request(input req_type r);
      rsp_type      res;
      int unsigned  span;
      int unsigned  f;
      span              = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      res.ok            = 1'b0;
      res.granted_frame = r.frame_index;
      res.frame_address = '0;
      case (r.mode)
         MODE_ALLOC: begin
            res.granted_frame = '0;
            for (f = 0; f < span && !res.ok; f++) begin
               if (!used_map[f / WORD_BITS][f % WORD_BITS]) begin
                  used_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                  res.ok            = 1'b1;
                  res.granted_frame = INDEX_W'(f);
               end
            end
         end
         MODE_MARK, MODE_FREE: begin
            if (r.frame_index < span) begin
               used_map[r.frame_index / WORD_BITS][r.frame_index % WORD_BITS] =
                  (r.mode == MODE_MARK);
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      if (res.ok)
         res.frame_address = ADDR_W'(res.granted_frame) << PAGE_SHIFT;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      if (errors < 10)
         $display("%t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      errors++;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      w;
      if (reset) begin
         for (w = 0; w < WORD_COUNT; w++)
            used_map[w] = '0;
         frame_limit = COUNT_RESET;
         expected_rsps.delete();
      end else begin
         if (csr_wr_en)
            frame_limit = csr_wr_data;
         // older transaction leaves before a new one is queued
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               note_mismatch("unexpected response ok/frame", rsp_data.ok,
                             rsp_data.granted_frame);
            end else begin
               want = expected_rsps.pop_front();
               checked++;
               if (rsp_data.ok !== want.ok)
                  note_mismatch("ok", want.ok, rsp_data.ok);
               if (rsp_data.granted_frame !== want.granted_frame)
                  note_mismatch("granted_frame", want.granted_frame, rsp_data.granted_frame);
               if (rsp_data.frame_address !== want.frame_address)
                  note_mismatch("frame_address", want.frame_address, rsp_data.frame_address);
            end
         end
         if (req_valid && !req_stall) begin
            want = serve_request(req_data);
            if (!want.ok)
               rejects++;
            else if (req_data.mode == MODE_ALLOC)
               grants++;
            expected_rsps.push_back(want);
         end
      end
      fail_count  <= errors;
      outstanding <= expected_rsps.size();
   end

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the frame bitmap allocator with directed and random requests under
// changing frame counts and idle patterns; a checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import fba_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNKNOWN = 2'd3;
   localparam int         QUIET_LIMIT  = 20000;
   localparam int         DRAIN_CYCLES = 140;
   localparam int         PHASE_ITEMS  = 300;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   int          fail_count;
   int          outstanding;
   int          checked;
   int          grants;
   int          rejects;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles  = 0;
   int          settings      = 0;
   int unsigned span          = MAX_FRAMES;

   frame_bitmap_allocator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frame_bitmap_allocator_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked),
      .grants      (grants),
      .rejects     (rejects)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL frame_bitmap_allocator_unit");
         $finish;
      end
   end

   task automatic send_req(input logic [1:0] op, input logic [INDEX_W-1:0] idx);
      req_type item;
      item.mode        = mode_type'(op);
      item.frame_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Block is idle once every queued transaction has come back.
   task automatic drain();
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic set_frame_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      span = (value > MAX_FRAMES) ? MAX_FRAMES : value;
      settings++;
   endtask

   task automatic random_item();
      int unsigned      pick;
      int unsigned      reach;
      logic [1:0]       op;
      logic [INDEX_W-1:0] idx;
      pick  = $urandom_range(99);
      reach = (span > 512) ? 512 : span;
      // mostly in-range targets near the low frames, sometimes anywhere
      if ($urandom_range(9) < 8 && reach > 0)
         idx = INDEX_W'($urandom_range(reach - 1));
      else
         idx = INDEX_W'($urandom);
      if (pick < 45)
         op = MODE_ALLOC;
      else if (pick < 70)
         op = MODE_FREE;
      else if (pick < 96)
         op = MODE_MARK;
      else
         op = MODE_UNKNOWN;
      send_req(op, idx);
   endtask

   initial begin : stimulus
      int                 phase;
      int                 sent;
      int                 next_cfg;
      logic [COUNT_W-1:0] value;
      send_idle_pct = 36;
      recv_idle_pct <= 83;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset count, repeats, top index, unknown mode
      send_req(MODE_ALLOC, 12'hFFF);
      send_req(MODE_ALLOC, 12'h000);
      send_req(MODE_MARK, 12'hFFF);
      send_req(MODE_FREE, 12'hFFF);
      send_req(MODE_FREE, 12'hFFF);
      send_req(MODE_MARK, 12'h000);
      send_req(MODE_MARK, 12'd4000);
      send_req(MODE_UNKNOWN, 12'hFFF);
      send_req(MODE_UNKNOWN, 12'h000);
      send_req(MODE_FREE, 12'h000);
      send_req(MODE_ALLOC, 12'h000);
      // no frames at all
      set_frame_count('0);
      send_req(MODE_ALLOC, 12'h000);
      send_req(MODE_MARK, 12'h000);
      send_req(MODE_FREE, 12'h000);
      // exhausted pool, edge of range, frame stranded above a lowered count
      set_frame_count(COUNT_W'(2));
      send_req(MODE_ALLOC, 12'h000);
      send_req(MODE_MARK, 12'h001);
      send_req(MODE_MARK, 12'h002);
      send_req(MODE_FREE, 12'd4000);
      // count beyond the bitmap size
      set_frame_count('1);
      send_req(MODE_MARK, 12'hFFF);
      send_req(MODE_FREE, 12'hFFF);
      send_req(MODE_ALLOC, 12'hFFF);
      set_frame_count(COUNT_W'(4097));
      send_req(MODE_FREE, 12'd4000);
      send_req(MODE_ALLOC, 12'h000);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct <= 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct <= 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         sent     = 0;
         next_cfg = 0;
         while (sent < PHASE_ITEMS) begin
            if (sent >= next_cfg) begin
               case ($urandom_range(12))
                  0:       value = '0;
                  1:       value = COUNT_W'(1);
                  2:       value = COUNT_W'(31);
                  3:       value = COUNT_W'(32);
                  4:       value = COUNT_W'(33);
                  5:       value = COUNT_W'(100);
                  6:       value = COUNT_W'(1000);
                  7:       value = COUNT_W'(4095);
                  8:       value = COUNT_W'(4096);
                  9:       value = COUNT_W'(4097);
                  10:      value = '1;
                  11:      value = COUNT_W'($urandom_range(64, 8));
                  default: value = COUNT_W'($urandom);
               endcase
               set_frame_count(value);
               next_cfg = sent + 50;
            end
            if ($urandom_range(9) == 0) begin
               // allocation run pushes the scan deeper into the bitmap
               repeat ($urandom_range(60, 20)) begin
                  send_req(MODE_ALLOC, INDEX_W'($urandom));
                  sent++;
               end
            end else begin
               random_item();
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d transactions: %0d frame grants, %0d rejected requests",
               checked, grants, rejects);
      $display("Used %0d frame_count settings over three sender/receiver idle mixes",
               settings);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS frame_bitmap_allocator_unit");
      else
         $display("FAIL frame_bitmap_allocator_unit");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/fba_pkg.sv
hdl/fba_ram.sv
hdl/fba_scan_unit.sv
hdl/fba_ctrl.sv
hdl/frame_bitmap_allocator_unit.sv
test/frame_bitmap_allocator_checker.sv
test/testbench.sv
